// File: hdl/ldes_pkg.sv
// Shared constants and types for the luma difference and squared-error sum block.
// Used by ldes_diff, ldes_accum and luma_difference_error_sum; depends on nothing.
`default_nettype none

package ldes_pkg;

    // Largest number of samples counted in one frame.
    localparam int unsigned MAX_SAMPLES = 4194304;
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int unsigned LUMA_W      = 8;
    localparam int unsigned SQ_W        = 2 * LUMA_W;
    localparam int unsigned SUM_W       = 38;
    localparam int unsigned TOTAL_W     = 23;

    localparam logic [LUMA_W-1:0] DIFF_BIAS = 8'h80;

    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 72;

    typedef struct packed {
        logic [LUMA_W-1:0] diff_pixel;
        logic [SQ_W-1:0]   sq;
        logic              last;
    } t_sq_item;

endpackage

`default_nettype wire

// File: hdl/ldes_diff.sv
// Input register and difference/square stage of the luma error sum block.
// Depends on ldes_pkg.
`default_nettype none

module ldes_diff (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [ldes_pkg::LUMA_W-1:0]    i_ref,
    input  wire logic [ldes_pkg::LUMA_W-1:0]    i_test,
    input  wire logic                           i_last,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output ldes_pkg::t_sq_item                  o_item
);

    logic                          r_v1;
    logic [ldes_pkg::LUMA_W-1:0]   r_ref;
    logic [ldes_pkg::LUMA_W-1:0]   r_test;
    logic                          r_last;
    logic                          r_v2;
    ldes_pkg::t_sq_item            r_item;

    logic                          rdy1;
    logic                          rdy2;
    logic [ldes_pkg::LUMA_W-1:0]   mag;
    ldes_pkg::t_sq_item            n_item;

    // Each stage refills whenever it is empty or its content moves on.
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        mag               = (r_ref >= r_test) ? (r_ref - r_test) : (r_test - r_ref);
        n_item.diff_pixel = ldes_pkg::DIFF_BIAS - r_ref + r_test;
        n_item.sq         = ldes_pkg::SQ_W'(mag) * ldes_pkg::SQ_W'(mag);
        n_item.last       = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && rdy1) begin
            r_ref  <= i_ref;
            r_test <= i_test;
            r_last <= i_last;
        end
        if (r_v1 && rdy2) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v2;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: hdl/ldes_accum.sv
// Accumulator and result register of the luma error sum block: saturating sum of
// squares, bounded sample counter and frame report. Depends on ldes_pkg.
`default_nettype none

module ldes_accum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire ldes_pkg::t_sq_item             i_item,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [ldes_pkg::LUMA_W-1:0]         o_diff_pixel,
    output logic                                o_frame_done,
    output logic [ldes_pkg::SUM_W-1:0]          o_squared_error_sum,
    output logic [ldes_pkg::TOTAL_W-1:0]        o_sample_total,
    output logic                                o_frames_identical,
    output logic                                o_count_overflow
);

    logic [ldes_pkg::SUM_W-1:0]    r_acc;
    logic [ldes_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_ovf;

    logic                          r_ov;
    logic [ldes_pkg::LUMA_W-1:0]   r_diff_pixel;
    logic                          r_frame_done;
    logic [ldes_pkg::SUM_W-1:0]    r_sum;
    logic [ldes_pkg::TOTAL_W-1:0]  r_total;
    logic                          r_ident;
    logic                          r_cnt_ovf;

    logic                          rdy;
    logic                          take;
    logic                          at_bound;
    logic [ldes_pkg::SUM_W:0]      wide_sum;
    logic [ldes_pkg::SUM_W-1:0]    n_acc;
    logic [ldes_pkg::CNT_W-1:0]    n_cnt;
    logic                          n_ovf;
    logic [63:0]                   cnt_ext;

    assign rdy     = !r_ov || i_ready;
    assign take    = i_valid && rdy;
    assign o_ready = rdy;

    // A carry out of the sum means the accumulator would pass its limit, so it sticks
    // at all ones.
    always_comb begin
        at_bound = r_cnt >= ldes_pkg::CNT_W'(ldes_pkg::MAX_SAMPLES);
        wide_sum = {1'b0, r_acc} + (ldes_pkg::SUM_W + 1)'(i_item.sq);
        if (at_bound) begin
            n_acc = r_acc;
            n_cnt = r_cnt;
            n_ovf = 1'b1;
        end else begin
            n_acc = wide_sum[ldes_pkg::SUM_W] ? '1 : wide_sum[ldes_pkg::SUM_W-1:0];
            n_cnt = r_cnt + ldes_pkg::CNT_W'(1);
            n_ovf = r_ovf;
        end
        cnt_ext = 64'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (rdy) begin
                r_ov <= i_valid;
            end
            if (take) begin
                if (i_item.last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                    r_ovf <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_diff_pixel <= i_item.diff_pixel;
            r_frame_done <= i_item.last;
            if (i_item.last) begin
                r_sum     <= n_acc;
                r_total   <= cnt_ext[ldes_pkg::TOTAL_W-1:0];
                r_ident   <= (n_acc == '0);
                r_cnt_ovf <= n_ovf;
            end else begin
                r_sum     <= '0;
                r_total   <= '0;
                r_ident   <= 1'b0;
                r_cnt_ovf <= 1'b0;
            end
        end
    end

    assign o_valid             = r_ov;
    assign o_diff_pixel        = r_diff_pixel;
    assign o_frame_done        = r_frame_done;
    assign o_squared_error_sum = r_sum;
    assign o_sample_total      = r_total;
    assign o_frames_identical  = r_ident;
    assign o_count_overflow    = r_cnt_ovf;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ldes_pkg::CNT_W'(ldes_pkg::MAX_SAMPLES))
        else $error("sample counter passed its bound");

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_item.last |=> r_acc == '0 && r_cnt == '0 && !r_ovf)
        else $error("accumulators not cleared after frame report");

    a_totals_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_frame_done |-> r_sum == '0 && r_total == '0 && !r_ident && !r_cnt_ovf)
        else $error("totals shown on an item that does not end a frame");

    a_ident_matches_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_frame_done |-> r_ident == (r_sum == '0))
        else $error("identical flag disagrees with the error sum");
`endif

endmodule

`default_nettype wire

// File: hdl/luma_difference_error_sum.sv
// Luma difference pixel and frame squared-error sum, streaming top level.
// Instantiates ldes_diff and ldes_accum; depends on ldes_pkg.
//
// Input channel (s_axis): one item is a co-located pair of luma samples, reference in
// tdata[7:0] and test in tdata[15:8]; tlast marks the final sample of a frame.
// Output channel (m_axis): one item per input item. tdata carries the difference pixel
// 0x80 - (ref - test) modulo 256; on an item with tlast high it also carries the
// frame's exact sum of squared differences, the sample count and the two flags,
// which are zero on all other items. The running sum and count clear after each
// frame report. Software derives mean and PSNR from the totals.
// From the input handshake the result passes the input register, the difference/square
// register, then the accumulate/result register. Throughput is one item per cycle
// unless the receiver stalls, bounded by the single accumulator update per cycle.
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the sum, the count
// and the overflow flag. When the receiver stalls, each stage keeps its item and the
// stages ahead of it still fill, so up to three items are held before s_axis_tready
// falls. The count stops at MAX_SAMPLES; later samples of that frame are left out of
// the totals and raise the overflow flag.
`default_nettype none

module luma_difference_error_sum (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [7:0] ref_luma, [15:8] test_luma
    input  wire logic [ldes_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [7:0] diff_pixel, [45:8] squared_error_sum, [68:46] sample_total,
    // [69] frames_identical, [70] count_overflow, [71] zero
    output logic [ldes_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    output logic                                   m_axis_tlast
);

    logic                              mid_valid;
    logic                              mid_ready;
    ldes_pkg::t_sq_item                mid_item;

    logic [ldes_pkg::LUMA_W-1:0]       diff_pixel;
    logic [ldes_pkg::SUM_W-1:0]        squared_error_sum;
    logic [ldes_pkg::TOTAL_W-1:0]      sample_total;
    logic                              frames_identical;
    logic                              count_overflow;

    ldes_diff u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ref   (s_axis_tdata[7:0]),
        .i_test  (s_axis_tdata[15:8]),
        .i_last  (s_axis_tlast),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_item  (mid_item)
    );

    ldes_accum u_accum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (mid_valid),
        .o_ready             (mid_ready),
        .i_item              (mid_item),
        .o_valid             (m_axis_tvalid),
        .i_ready             (m_axis_tready),
        .o_diff_pixel        (diff_pixel),
        .o_frame_done        (m_axis_tlast),
        .o_squared_error_sum (squared_error_sum),
        .o_sample_total      (sample_total),
        .o_frames_identical  (frames_identical),
        .o_count_overflow    (count_overflow)
    );

    assign m_axis_tdata = {1'b0, count_overflow, frames_identical, sample_total,
                           squared_error_sum, diff_pixel};

endmodule

`default_nettype wire
